// ===== rtl/jvn_pkg.sv =====
package jvn_pkg;

   localparam int JOINTS  = 6;
   localparam int ANG_W   = 16;
   localparam int SPD_W   = 14;
   localparam int VEL_W   = 15;
   localparam int PROD_W  = ANG_W + SPD_W;
   localparam int QBITS   = SPD_W;
   localparam int DATA_W  = 32;

   localparam int STAGES  = QBITS + 3;
   localparam int ST_ERR  = 0;
   localparam int ST_PEAK = 1;
   localparam int ST_DIV0 = 2;
   localparam int ST_OUT  = STAGES - 1;

   localparam int IDX_W   = $clog2(JOINTS + 2);
   localparam int JIDX_W  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int ADDR_W  = IDX_W + 2;

   localparam logic [IDX_W-1:0] REG_STOP  = IDX_W'(JOINTS);
   localparam logic [IDX_W-1:0] REG_SPEED = IDX_W'(JOINTS + 1);

   localparam logic [ANG_W-1:0] STOP_RESET  = ANG_W'(30);
   localparam logic [SPD_W-1:0] SPEED_RESET = SPD_W'(2000);

   typedef logic [JOINTS-1:0][ANG_W-1:0] ang_array_type;
   typedef logic [JOINTS-1:0][VEL_W-1:0] vel_array_type;
   typedef logic [STAGES-1:0]            load_type;

   typedef struct packed {
      ang_array_type     target;
      logic [ANG_W-1:0]  stop;
      logic [SPD_W-1:0]  speed;
   } cfg_type;

endpackage

// ===== rtl/jvn_csr.sv =====
module jvn_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [jvn_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [jvn_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [jvn_pkg::DATA_W-1:0]   csr_prdata,
   output jvn_pkg::cfg_type             cfg
);

   jvn_pkg::cfg_type              cfg_ff;
   jvn_pkg::cfg_type              cfg_in;
   logic [jvn_pkg::IDX_W-1:0]     idx;
   logic [jvn_pkg::JIDX_W-1:0]    jidx;
   logic                          wr;

   assign idx  = csr_paddr[jvn_pkg::ADDR_W-1:2];
   assign jidx = idx[jvn_pkg::JIDX_W-1:0];
   assign wr   = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            jvn_pkg::REG_STOP: begin
               cfg_in.stop = csr_pwdata[jvn_pkg::ANG_W-1:0];
            end
            jvn_pkg::REG_SPEED: begin
               cfg_in.speed = csr_pwdata[jvn_pkg::SPD_W-1:0];
            end
            default: begin
               if (idx < jvn_pkg::REG_STOP) begin
                  cfg_in.target[jidx] = csr_pwdata[jvn_pkg::ANG_W-1:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target <= '0;
         cfg_ff.stop   <= jvn_pkg::STOP_RESET;
         cfg_ff.speed  <= jvn_pkg::SPEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         jvn_pkg::REG_STOP: begin
            csr_prdata = jvn_pkg::DATA_W'(cfg_ff.stop);
         end
         jvn_pkg::REG_SPEED: begin
            csr_prdata = jvn_pkg::DATA_W'(cfg_ff.speed);
         end
         default: begin
            if (idx < jvn_pkg::REG_STOP) begin
               csr_prdata = jvn_pkg::DATA_W'(cfg_ff.target[jidx]);
            end else begin
               csr_prdata = '0;
            end
         end
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/jvn_lane.sv =====
module jvn_lane (
   input  logic                        clock,
   input  jvn_pkg::load_type           load,
   input  logic [jvn_pkg::ANG_W-1:0]   target,
   input  logic [jvn_pkg::ANG_W-1:0]   meas,
   input  logic [jvn_pkg::SPD_W-1:0]   max_speed,
   input  logic [jvn_pkg::ANG_W-1:0]   peak,
   input  logic                        done,
   output logic [jvn_pkg::ANG_W-1:0]   mag,
   output logic [jvn_pkg::VEL_W-1:0]   vel
);

   localparam int QB = jvn_pkg::QBITS;
   localparam int PW = jvn_pkg::PROD_W;

   // error stage
   logic [jvn_pkg::ANG_W:0]     err;
   logic [jvn_pkg::ANG_W:0]     err_neg;
   logic                        sign0_ff;
   logic [jvn_pkg::ANG_W-1:0]   mag_ff;
   logic [jvn_pkg::ANG_W-1:0]   mag_in;

   // product stage
   logic                        sign1_ff;
   logic [PW-1:0]               prod_ff;
   logic [PW-1:0]               prod_in;

   // restoring divider, one quotient bit per stage
   logic [PW-1:0]               rem_ff  [QB];
   logic [PW-1:0]               rem_in  [QB];
   logic [PW-1:0]               rem_src [QB];
   logic [PW-1:0]               sub_val [QB];
   logic [QB-1:0]               quo_ff  [QB];
   logic [QB-1:0]               quo_in  [QB];
   logic [QB-1:0]               quo_src [QB];
   logic [jvn_pkg::ANG_W-1:0]   dvs_ff  [QB];
   logic [jvn_pkg::ANG_W-1:0]   dvs_src [QB];
   logic                        sgn_ff  [QB];
   logic                        sgn_src [QB];

   logic [jvn_pkg::VEL_W-1:0]   vel_ff;
   logic [jvn_pkg::VEL_W-1:0]   vel_in;
   logic [jvn_pkg::VEL_W-1:0]   q_ext;

   assign err     = {1'b0, target} - {1'b0, meas};
   assign err_neg = (jvn_pkg::ANG_W + 1)'(0) - err;
   assign mag_in  = err[jvn_pkg::ANG_W] ? err_neg[jvn_pkg::ANG_W-1:0]
                                        : err[jvn_pkg::ANG_W-1:0];
   assign prod_in = PW'(mag_ff) * PW'(max_speed);

   always_comb begin
      for (int i = 0; i < QB; i++) begin
         if (i == 0) begin
            rem_src[i] = prod_ff;
            quo_src[i] = '0;
            dvs_src[i] = peak;
            sgn_src[i] = sign1_ff;
         end else begin
            rem_src[i] = rem_ff[i-1];
            quo_src[i] = quo_ff[i-1];
            dvs_src[i] = dvs_ff[i-1];
            sgn_src[i] = sgn_ff[i-1];
         end
         sub_val[i] = PW'(dvs_src[i]) << (QB - 1 - i);
         quo_in[i]  = quo_src[i];
         if (rem_src[i] >= sub_val[i]) begin
            rem_in[i] = rem_src[i] - sub_val[i];
            quo_in[i][QB-1-i] = 1'b1;
         end else begin
            rem_in[i] = rem_src[i];
         end
      end
   end

   assign q_ext  = jvn_pkg::VEL_W'(quo_ff[QB-1]);
   assign vel_in = done ? '0 :
                   (sgn_ff[QB-1] ? jvn_pkg::VEL_W'(0) - q_ext : q_ext);

   always_ff @(posedge clock) begin
      if (load[jvn_pkg::ST_ERR]) begin
         sign0_ff <= err[jvn_pkg::ANG_W];
         mag_ff   <= mag_in;
      end
      if (load[jvn_pkg::ST_PEAK]) begin
         sign1_ff <= sign0_ff;
         prod_ff  <= prod_in;
      end
      for (int i = 0; i < QB; i++) begin
         if (load[jvn_pkg::ST_DIV0 + i]) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
            dvs_ff[i] <= dvs_src[i];
            sgn_ff[i] <= sgn_src[i];
         end
      end
      if (load[jvn_pkg::ST_OUT]) begin
         vel_ff <= vel_in;
      end
   end

   assign mag = mag_ff;
   assign vel = vel_ff;

endmodule

// ===== rtl/jvn_merge.sv =====
module jvn_merge (
   input  logic                        clock,
   input  logic                        load,
   input  jvn_pkg::ang_array_type      mags,
   input  logic [jvn_pkg::ANG_W-1:0]   stop,
   output logic [jvn_pkg::ANG_W-1:0]   peak,
   output logic                        done
);

   logic [jvn_pkg::ANG_W-1:0] peak_ff;
   logic [jvn_pkg::ANG_W-1:0] peak_in;
   logic                      done_ff;
   logic                      done_in;

   always_comb begin
      peak_in = '0;
      for (int j = 0; j < jvn_pkg::JOINTS; j++) begin
         if (mags[j] > peak_in) begin
            peak_in = mags[j];
         end
      end
   end

   assign done_in = (peak_in == '0) || (peak_in < stop);

   always_ff @(posedge clock) begin
      if (load) begin
         peak_ff <= peak_in;
         done_ff <= done_in;
      end
   end

   assign peak = peak_ff;
   assign done = done_ff;

endmodule

// ===== rtl/joint_velocity_normalizer.sv =====
// Joint velocity normalizer. Each transfer on the req_ channel carries one
// sample of measured joint angles (hundredths of a degree); the rsp_ channel
// returns one velocity per joint, scaled so the joint with the largest error
// against its target runs at +/- max_speed, or all zeros with done_res set
// when the largest error is zero or below stop_threshold. One sample is
// taken every cycle while rsp_ready is high. The per-joint restoring
// divider resolves one quotient bit per pipeline stage (14 stages) behind
// an error stage and a stage that finds the largest error and forms the
// products, followed by the output register. Targets, stop_threshold and
// max_speed sit at byte addresses 4*i of the csr_ port. The user must write
// them only while no sample is in flight; the block does not enforce this.
module joint_velocity_normalizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [jvn_pkg::ANG_W-1:0]         req_meas_joint1,
   input  logic [jvn_pkg::ANG_W-1:0]         req_meas_joint2,
   input  logic [jvn_pkg::ANG_W-1:0]         req_meas_joint3,
   input  logic [jvn_pkg::ANG_W-1:0]         req_meas_joint4,
   input  logic [jvn_pkg::ANG_W-1:0]         req_meas_joint5,
   input  logic [jvn_pkg::ANG_W-1:0]         req_meas_joint6,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [jvn_pkg::VEL_W-1:0]  rsp_vel_joint1,
   output logic signed [jvn_pkg::VEL_W-1:0]  rsp_vel_joint2,
   output logic signed [jvn_pkg::VEL_W-1:0]  rsp_vel_joint3,
   output logic signed [jvn_pkg::VEL_W-1:0]  rsp_vel_joint4,
   output logic signed [jvn_pkg::VEL_W-1:0]  rsp_vel_joint5,
   output logic signed [jvn_pkg::VEL_W-1:0]  rsp_vel_joint6,
   output logic                              rsp_done_res,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [jvn_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [jvn_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [jvn_pkg::DATA_W-1:0]        csr_prdata,
   output logic                              csr_pready
);

   jvn_pkg::cfg_type          cfg;
   jvn_pkg::ang_array_type    meas;
   jvn_pkg::ang_array_type    mags;
   jvn_pkg::vel_array_type    vels;
   jvn_pkg::load_type         valid_ff;
   jvn_pkg::load_type         valid_in;
   jvn_pkg::load_type         free;
   jvn_pkg::load_type         load;
   logic [jvn_pkg::ANG_W-1:0] peak;
   logic                      done_peak;
   logic                      done_pipe_ff [jvn_pkg::QBITS];
   logic                      done_res_ff;

   assign meas[0] = req_meas_joint1;
   assign meas[1] = req_meas_joint2;
   assign meas[2] = req_meas_joint3;
   assign meas[3] = req_meas_joint4;
   assign meas[4] = req_meas_joint5;
   assign meas[5] = req_meas_joint6;

   jvn_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   assign csr_pready = 1'b1;

   // stage handshake, a stage loads when its predecessor holds a sample and it is empty or its successor frees up
   always_comb begin
      free[jvn_pkg::ST_OUT] = !valid_ff[jvn_pkg::ST_OUT] || rsp_ready;
      for (int k = jvn_pkg::ST_OUT - 1; k >= 0; k--) begin
         free[k] = !valid_ff[k] || free[k+1];
      end
      load[0] = req_valid && free[0];
      for (int k = 1; k < jvn_pkg::STAGES; k++) begin
         load[k] = valid_ff[k-1] && free[k];
      end
      valid_in = load | (valid_ff & ~free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   for (genvar j = 0; j < jvn_pkg::JOINTS; j++) begin : g_lane
      jvn_lane u_lane (
         .clock     (clock),
         .load      (load),
         .target    (cfg.target[j]),
         .meas      (meas[j]),
         .max_speed (cfg.speed),
         .peak      (peak),
         .done      (done_pipe_ff[jvn_pkg::QBITS-1]),
         .mag       (mags[j]),
         .vel       (vels[j])
      );
   end

   jvn_merge u_merge (
      .clock (clock),
      .load  (load[jvn_pkg::ST_PEAK]),
      .mags  (mags),
      .stop  (cfg.stop),
      .peak  (peak),
      .done  (done_peak)
   );

   always_ff @(posedge clock) begin
      for (int i = 0; i < jvn_pkg::QBITS; i++) begin
         if (load[jvn_pkg::ST_DIV0 + i]) begin
            done_pipe_ff[i] <= (i == 0) ? done_peak : done_pipe_ff[(i == 0) ? 0 : i - 1];
         end
      end
      if (load[jvn_pkg::ST_OUT]) begin
         done_res_ff <= done_pipe_ff[jvn_pkg::QBITS-1];
      end
   end

   assign req_ready      = free[0];
   assign rsp_valid      = valid_ff[jvn_pkg::ST_OUT];
   assign rsp_vel_joint1 = vels[0];
   assign rsp_vel_joint2 = vels[1];
   assign rsp_vel_joint3 = vels[2];
   assign rsp_vel_joint4 = vels[3];
   assign rsp_vel_joint5 = vels[4];
   assign rsp_vel_joint6 = vels[5];
   assign rsp_done_res   = done_res_ff;

endmodule

// ===== rtl/jvn_checker.sv =====
module jvn_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [jvn_pkg::VEL_W-1:0]  rsp_vel_joint1,
   input  logic signed [jvn_pkg::VEL_W-1:0]  rsp_vel_joint2,
   input  logic signed [jvn_pkg::VEL_W-1:0]  rsp_vel_joint3,
   input  logic signed [jvn_pkg::VEL_W-1:0]  rsp_vel_joint4,
   input  logic signed [jvn_pkg::VEL_W-1:0]  rsp_vel_joint5,
   input  logic signed [jvn_pkg::VEL_W-1:0]  rsp_vel_joint6,
   input  logic                              rsp_done_res
);

   localparam logic [jvn_pkg::VEL_W-1:0] VEL_MIN = {1'b1, {(jvn_pkg::VEL_W-1){1'b0}}};

   logic all_zero;
   logic any_min;

   assign all_zero = (rsp_vel_joint1 == '0) && (rsp_vel_joint2 == '0) &&
                     (rsp_vel_joint3 == '0) && (rsp_vel_joint4 == '0) &&
                     (rsp_vel_joint5 == '0) && (rsp_vel_joint6 == '0);
   assign any_min  = (rsp_vel_joint1 == VEL_MIN) || (rsp_vel_joint2 == VEL_MIN) ||
                     (rsp_vel_joint3 == VEL_MIN) || (rsp_vel_joint4 == VEL_MIN) ||
                     (rsp_vel_joint5 == VEL_MIN) || (rsp_vel_joint6 == VEL_MIN);

   // stalled result holds (checked on done_res and joints 1 and 6)
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_done_res) &&
      $stable(rsp_vel_joint1) && $stable(rsp_vel_joint6))
      else $error("result changed while stalled");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> all_zero)
      else $error("done result with nonzero velocity");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // empty output slot means the pipe can take a sample
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_vel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !any_min)
      else $error("velocity out of range");

endmodule

bind joint_velocity_normalizer jvn_checker u_jvn_checker (.*);

// ===== verif/tb_joint_velocity_normalizer.sv =====
module tb_joint_velocity_normalizer;
   timeunit 1ns;
   timeprecision 1ps;

   import jvn_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 125;
   localparam int REPORT_CAP    = 40;
   localparam int REG_TARGET0   = 0;

   typedef struct packed {
      vel_array_type vel;
      logic          done;
   } vel_result_type;

   class velocity_check;
      ang_array_type     target;
      logic [ANG_W-1:0]  stop;
      logic [SPD_W-1:0]  speed;
      vel_result_type    vel_expected[$];
      int                errors;
      int                samples;
      int                done_seen;

      function new();
         target    = '0;
         stop      = STOP_RESET;
         speed     = SPEED_RESET;
         errors    = 0;
         samples   = 0;
         done_seen = 0;
      endfunction

      function void set_register(int idx, logic [DATA_W-1:0] value);
         if (idx < JOINTS) begin
            target[idx] = value[ANG_W-1:0];
         end else if (idx == int'(REG_STOP)) begin
            stop = value[ANG_W-1:0];
         end else if (idx == int'(REG_SPEED)) begin
            speed = value[SPD_W-1:0];
         end
      endfunction

      function logic [DATA_W-1:0] register_value(int idx);
         if (idx < JOINTS) begin
            return DATA_W'(target[idx]);
         end else if (idx == int'(REG_STOP)) begin
            return DATA_W'(stop);
         end
         return DATA_W'(speed);
      endfunction

      function vel_result_type predict_velocities(ang_array_type meas);
         longint         err[JOINTS];
         longint         mag;
         longint         peak;
         vel_result_type r;
         peak = 0;
         for (int j = 0; j < JOINTS; j++) begin
            err[j] = longint'(target[j]) - longint'(meas[j]);
            mag = (err[j] < 0) ? -err[j] : err[j];
            if (mag > peak) begin
               peak = mag;
            end
         end
         r.vel = '0;
         if (peak == 0 || peak < longint'(stop)) begin
            r.done = 1'b1;
         end else begin
            r.done = 1'b0;
            for (int j = 0; j < JOINTS; j++) begin
               r.vel[j] = VEL_W'((err[j] * longint'(speed)) / peak);
            end
         end
         return r;
      endfunction

      function void note_sample(ang_array_type meas);
         vel_expected.push_back(predict_velocities(meas));
         samples++;
      endfunction

      function void check_velocities(vel_array_type vel, logic done);
         vel_result_type want;
         if (vel_expected.size() == 0) begin
            if (errors < REPORT_CAP) begin
               $display("%t: result transfer with no sample outstanding", $time);
            end
            errors++;
            return;
         end
         want = vel_expected.pop_front();
         if (want.done) begin
            done_seen++;
         end
         for (int j = 0; j < JOINTS; j++) begin
            if (vel[j] !== want.vel[j]) begin
               if (errors < REPORT_CAP) begin
                  $display("%t: vel_joint%0d expected %0d actual %0d", $time, j + 1,
                           $signed(want.vel[j]), $signed(vel[j]));
               end
               errors++;
            end
         end
         if (done !== want.done) begin
            if (errors < REPORT_CAP) begin
               $display("%t: done_res expected %0b actual %0b", $time, want.done, done);
            end
            errors++;
         end
      endfunction

      function int pending();
         return vel_expected.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   ang_array_type       req_meas = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic signed [VEL_W-1:0] rsp_vel_joint1, rsp_vel_joint2, rsp_vel_joint3;
   logic signed [VEL_W-1:0] rsp_vel_joint4, rsp_vel_joint5, rsp_vel_joint6;
   logic                rsp_done_res;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr = '0;
   logic [DATA_W-1:0]   csr_pwdata = '0;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   velocity_check sb;
   int            idle_pct = 0;
   int            stall_left = 0;
   int            cycle_count = 0;
   int            read_faults = 0;
   int            setting_count = 0;

   joint_velocity_normalizer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_meas_joint1 (req_meas[0]),
      .req_meas_joint2 (req_meas[1]),
      .req_meas_joint3 (req_meas[2]),
      .req_meas_joint4 (req_meas[3]),
      .req_meas_joint5 (req_meas[4]),
      .req_meas_joint6 (req_meas[5]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_vel_joint1  (rsp_vel_joint1),
      .rsp_vel_joint2  (rsp_vel_joint2),
      .rsp_vel_joint3  (rsp_vel_joint3),
      .rsp_vel_joint4  (rsp_vel_joint4),
      .rsp_vel_joint5  (rsp_vel_joint5),
      .rsp_vel_joint6  (rsp_vel_joint6),
      .rsp_done_res    (rsp_done_res),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  sb.pending());
         $display("status: fail");
         $finish;
      end
   end

   // receiver back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(1, 9) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_velocities({rsp_vel_joint6, rsp_vel_joint5, rsp_vel_joint4,
                              rsp_vel_joint3, rsp_vel_joint2, rsp_vel_joint1},
                             rsp_done_res);
      end
   end

   function automatic ang_array_type joints(int j1, int j2, int j3, int j4, int j5, int j6);
      ang_array_type s;
      s[0] = ANG_W'(j1);
      s[1] = ANG_W'(j2);
      s[2] = ANG_W'(j3);
      s[3] = ANG_W'(j4);
      s[4] = ANG_W'(j5);
      s[5] = ANG_W'(j6);
      return s;
   endfunction

   task automatic csr_write(input int idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(idx * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_register(idx, value);
   endtask

   task automatic csr_read_check(input int idx);
      logic [DATA_W-1:0] got;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_W'(idx * 4);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== sb.register_value(idx)) begin
         $display("%t: register %0d read expected %0h actual %0h", $time, idx,
                  sb.register_value(idx), got);
         read_faults++;
      end
   endtask

   task automatic check_registers();
      for (int i = 0; i < JOINTS + 2; i++) begin
         csr_read_check(i);
      end
   endtask

   // block must be empty before register writes
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (STAGES + 2) @(posedge clock);
   endtask

   task automatic set_phase(input ang_array_type tgt, input logic [DATA_W-1:0] stop,
                            input logic [DATA_W-1:0] speed);
      logic [15:0] upper;
      settle();
      for (int j = 0; j < JOINTS; j++) begin
         upper = $urandom_range(0, 1) ? 16'($urandom) : 16'h0;
         csr_write(REG_TARGET0 + j, {upper, tgt[j]});
      end
      csr_write(int'(REG_STOP), stop);
      csr_write(int'(REG_SPEED), speed);
      check_registers();
      setting_count++;
   endtask

   task automatic send_sample(input ang_array_type meas);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_meas  <= meas;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(meas);
   endtask

   function automatic logic [ANG_W-1:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return ANG_W'(36000);
         2: return '1;
         3: return ANG_W'($urandom);
         default: return ANG_W'($urandom_range(0, 36000));
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_stop();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 32'd30;
         2: return 32'd36000;
         3: return $urandom;
         4: return 32'hFFFF_FFFF;
         default: return DATA_W'($urandom_range(0, 300));
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_speed();
      case ($urandom_range(0, 8))
         0: return '0;
         1: return 32'd1;
         2: return 32'd10000;
         3: return $urandom;
         4: return 32'd2000;
         5: return 32'h0000_3FFF;
         default: return DATA_W'($urandom_range(1, 10000));
      endcase
   endfunction

   function automatic ang_array_type random_sample();
      ang_array_type s;
      int            span;
      int            kind;
      span = int'(sb.stop) + 3;
      kind = $urandom_range(0, 9);
      for (int j = 0; j < JOINTS; j++) begin
         if (kind <= 2) begin
            // close to target, straddling the stop threshold
            s[j] = ANG_W'(int'(sb.target[j]) + int'($urandom_range(0, 2 * span)) - span);
         end else if (kind <= 7) begin
            s[j] = ANG_W'($urandom_range(0, 36000));
         end else if (kind == 8) begin
            s[j] = ANG_W'($urandom);
         end else begin
            case ($urandom_range(0, 3))
               0: s[j] = '0;
               1: s[j] = '1;
               2: s[j] = ANG_W'(36000);
               default: s[j] = sb.target[j];
            endcase
         end
      end
      return s;
   endfunction

   initial begin
      ang_array_type tgt;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      check_registers();
      idle_pct = 20;

      // reset settings: targets zero, threshold 30, speed 2000
      send_sample(joints(0, 0, 0, 0, 0, 0));
      send_sample(joints(29, 29, 29, 29, 29, 29));
      send_sample(joints(30, 0, 0, 0, 0, 0));
      send_sample(joints(65535, 65535, 65535, 65535, 65535, 65535));

      tgt = joints(0, 36000, 65535, 18000, 100, 35999);
      set_phase(tgt, 32'd30, 32'd10000);
      send_sample(tgt);
      send_sample(joints(36000, 0, 0, 18000, 0, 36000));
      send_sample(joints(0, 0, 0, 0, 0, 0));
      send_sample(joints(65535, 65535, 65535, 65535, 65535, 65535));
      send_sample(joints(30, 35990, 65506, 18029, 71, 36010));

      // zero threshold: done only on exact match
      set_phase(tgt, 32'd0, 32'd16383);
      send_sample(tgt);
      send_sample(joints(0, 36000, 65534, 18000, 100, 35999));
      send_sample(joints(1, 35999, 65535, 18001, 99, 35999));

      // zero speed while not done
      set_phase(tgt, 32'd30, 32'd0);
      send_sample(joints(0, 0, 0, 0, 0, 0));
      send_sample(tgt);

      // widest threshold, upper bits set in the written words
      set_phase(joints(65535, 0, 0, 0, 0, 0), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_sample(joints(0, 0, 0, 0, 0, 0));
      send_sample(joints(1000, 1000, 1000, 1000, 1000, 1000));
      send_sample(joints(0, 65535, 0, 65535, 0, 65535));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         for (int j = 0; j < JOINTS; j++) begin
            tgt[j] = pick_angle();
         end
         set_phase(tgt, pick_stop(), pick_speed());
         idle_pct = (p == RANDOM_PHASES - 1) ? 0 : $urandom_range(0, 4) * 10;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_sample(random_sample());
         end
      end

      settle();
      $display("covered %0d samples over %0d register settings plus reset values",
               sb.samples, setting_count);
      $display("%0d results were done, %0d moving", sb.done_seen,
               sb.samples - sb.done_seen);
      if (sb.errors == 0 && read_faults == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== joint_velocity_normalizer.f =====
rtl/jvn_pkg.sv
rtl/jvn_csr.sv
rtl/jvn_lane.sv
rtl/jvn_merge.sv
rtl/joint_velocity_normalizer.sv
rtl/jvn_checker.sv
verif/tb_joint_velocity_normalizer.sv
